// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/deqs_pkg.sv -----
package deqs_pkg;

    localparam int OP_W  = 3;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_PEEK       = 3'd4;
    localparam logic [OP_W-1:0] OP_FIND       = 3'd5;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic start;      // item accepted this cycle
        logic cap_front;  // read data -> data field
        logic rd_back;    // read slot before tail
        logic cap_back;   // read data -> back_data field
        logic scan;       // compare one entry, advance
        logic load_out;   // move result into output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic is_peek;
        logic scan_hit;
        logic scan_last;
        logic out_free;
    } t_dp_stat;

endpackage

// ----- rtl/deqs_ctrl.sv -----
module deqs_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [deqs_pkg::OP_W-1:0]     i_in_op,
    output logic                          o_in_ready,
    output deqs_pkg::t_dp_cmd             o_cmd,
    input  deqs_pkg::t_dp_stat            i_stat
);

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_RD_FRONT = 5'b00010,
        S_RD_BACK  = 5'b00100,
        S_SCAN     = 5'b01000,
        S_OUT      = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    unique case (i_in_op) inside
                        deqs_pkg::OP_POP_FRONT, deqs_pkg::OP_POP_BACK,
                        deqs_pkg::OP_PEEK: begin
                            n_state = i_stat.empty ? S_OUT : S_RD_FRONT;
                        end
                        deqs_pkg::OP_FIND: begin
                            n_state = i_stat.empty ? S_OUT : S_SCAN;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_RD_FRONT: begin
                o_cmd.cap_front = 1'b1;
                if (i_stat.is_peek) begin
                    o_cmd.rd_back = 1'b1;
                    n_state       = S_RD_BACK;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_RD_BACK: begin
                o_cmd.cap_back = 1'b1;
                n_state        = S_OUT;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_hit || i_stat.scan_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/deqs_dp.sv -----
module deqs_dp #(
    parameter int  CAPACITY = 1024,
    localparam int IW       = $clog2(CAPACITY),
    localparam int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  deqs_pkg::t_dp_cmd              i_cmd,
    output deqs_pkg::t_dp_stat             o_stat,
    input  logic [deqs_pkg::OP_W-1:0]      i_op,
    input  logic [deqs_pkg::VAL_W-1:0]     i_value,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [deqs_pkg::VAL_W-1:0]     o_data,
    output logic [deqs_pkg::VAL_W-1:0]     o_back_data,
    output logic [IW-1:0]                  o_position,
    output logic [CW-1:0]                  o_occupancy,
    output logic [deqs_pkg::ST_W-1:0]      o_status
);

    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + IW'(1);
    endfunction

    function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] idx);
        return (idx == '0) ? LAST_IDX : idx - IW'(1);
    endfunction

    logic [deqs_pkg::VAL_W-1:0] r_mem [CAPACITY];
    logic [deqs_pkg::VAL_W-1:0] r_rd;

    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic          r_out_valid;

    logic [deqs_pkg::OP_W-1:0]  r_op;
    logic [deqs_pkg::VAL_W-1:0] r_value;
    logic [deqs_pkg::VAL_W-1:0] r_data;
    logic [deqs_pkg::VAL_W-1:0] r_back;
    logic [IW-1:0]              r_pos;
    logic [IW-1:0]              r_scan_addr;
    logic [deqs_pkg::ST_W-1:0]  r_status;

    logic                       mem_wr;
    logic                       mem_rd;
    logic [IW-1:0]              mem_addr;
    logic [deqs_pkg::ST_W-1:0]  start_status;
    logic                       empty;
    logic                       full;
    logic                       scan_hit;
    logic                       scan_last;

    assign empty     = (r_count == '0);
    assign full      = (r_count == FULL_CNT);
    assign scan_hit  = (r_rd == r_value);
    assign scan_last = ((CW'(r_pos) + CW'(1)) == r_count);

    assign o_stat.empty     = empty;
    assign o_stat.is_peek   = (r_op == deqs_pkg::OP_PEEK);
    assign o_stat.scan_hit  = scan_hit;
    assign o_stat.scan_last = scan_last;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    // pointer updates and memory port selection
    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        mem_wr       = 1'b0;
        mem_rd       = 1'b0;
        mem_addr     = r_head;
        start_status = deqs_pkg::ST_OK;
        if (i_cmd.start) begin
            unique case (i_op)
                deqs_pkg::OP_PUSH_FRONT: begin
                    if (full) begin
                        start_status = deqs_pkg::ST_FULL;
                    end else begin
                        n_head   = ring_prev(r_head);
                        mem_addr = n_head;
                        mem_wr   = 1'b1;
                        n_count  = r_count + CW'(1);
                    end
                end
                deqs_pkg::OP_PUSH_BACK: begin
                    if (full) begin
                        start_status = deqs_pkg::ST_FULL;
                    end else begin
                        mem_addr = r_tail;
                        mem_wr   = 1'b1;
                        n_tail   = ring_next(r_tail);
                        n_count  = r_count + CW'(1);
                    end
                end
                deqs_pkg::OP_POP_FRONT: begin
                    if (empty) begin
                        start_status = deqs_pkg::ST_EMPTY;
                    end else begin
                        mem_addr = r_head;
                        mem_rd   = 1'b1;
                        n_head   = ring_next(r_head);
                        n_count  = r_count - CW'(1);
                    end
                end
                deqs_pkg::OP_POP_BACK: begin
                    if (empty) begin
                        start_status = deqs_pkg::ST_EMPTY;
                    end else begin
                        n_tail   = ring_prev(r_tail);
                        mem_addr = n_tail;
                        mem_rd   = 1'b1;
                        n_count  = r_count - CW'(1);
                    end
                end
                deqs_pkg::OP_PEEK: begin
                    if (empty) begin
                        start_status = deqs_pkg::ST_EMPTY;
                    end else begin
                        mem_addr = r_head;
                        mem_rd   = 1'b1;
                    end
                end
                deqs_pkg::OP_FIND: begin
                    start_status = deqs_pkg::ST_NOT_FOUND;
                    if (!empty) begin
                        mem_addr = r_head;
                        mem_rd   = 1'b1;
                    end
                end
                default: begin
                    start_status = deqs_pkg::ST_OK;
                end
            endcase
        end else if (i_cmd.rd_back) begin
            mem_addr = ring_prev(r_tail);
            mem_rd   = 1'b1;
        end else if (i_cmd.scan && !scan_hit && !scan_last) begin
            mem_addr = ring_next(r_scan_addr);
            mem_rd   = 1'b1;
        end
    end

    // single-port ring store, registered read
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[mem_addr] <= i_value;
        end
        if (mem_rd) begin
            r_rd <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op        <= i_op;
            r_value     <= i_value;
            r_data      <= '0;
            r_back      <= '0;
            r_pos       <= '0;
            r_status    <= start_status;
            r_scan_addr <= r_head;
        end
        if (i_cmd.cap_front) begin
            r_data <= r_rd;
        end
        if (i_cmd.cap_back) begin
            r_back <= r_rd;
        end
        if (i_cmd.scan) begin
            if (scan_hit) begin
                r_status <= deqs_pkg::ST_OK;
            end else if (scan_last) begin
                r_pos <= '0;
            end else begin
                r_pos       <= r_pos + IW'(1);
                r_scan_addr <= ring_next(r_scan_addr);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_data      <= r_data;
            o_back_data <= r_back;
            o_position  <= r_pos;
            o_occupancy <= r_count;
            o_status    <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/double_ended_queue_with_search.sv -----
// Double-ended queue of signed 32-bit words held in a single-port ring
// memory of CAPACITY entries. Each input item carries an operation in
// s_axis_tuser (push front, push back, pop front, pop back, peek, find)
// and a word or search key in s_axis_tdata; each item yields exactly one
// result item with data, back data, position, occupancy and a status
// (ok, empty, full push refused, not found). Items are handled one at a
// time, each step bound by the one memory port: an accepted push writes
// its word, a pop reads one end, a peek reads front and back in turn, a
// pop or peek on an empty queue reads nothing, and a find compares
// entries one per cycle, up to the occupancy. The result sits in an
// output register, so the next item is taken while it waits for
// m_axis_tready. No clearing pass after reset: the queue is empty and
// unwritten slots are never read.
`include "assert_macros.svh"

module double_ended_queue_with_search #(
    parameter int  CAPACITY = 1024,
    localparam int IW       = $clog2(CAPACITY),
    localparam int CW       = $clog2(CAPACITY + 1),
    localparam int OUT_W    = 2 * deqs_pkg::VAL_W + IW + CW,
    localparam int TD_W     = ((OUT_W + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input item
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [deqs_pkg::VAL_W-1:0]    s_axis_tdata,  // value
    input  logic [deqs_pkg::OP_W-1:0]     s_axis_tuser,  // op
    // result item
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // data, back_data, position, occupancy, zero pad
    output logic [TD_W-1:0]               m_axis_tdata,
    output logic [deqs_pkg::ST_W-1:0]     m_axis_tuser   // status
);

    deqs_pkg::t_dp_cmd  w_cmd;
    deqs_pkg::t_dp_stat w_stat;

    logic [deqs_pkg::VAL_W-1:0] w_data;
    logic [deqs_pkg::VAL_W-1:0] w_back;
    logic [IW-1:0]              w_pos;
    logic [CW-1:0]              w_occ;
    logic [deqs_pkg::ST_W-1:0]  w_status;

    // sequencing: accept, memory reads, scan, result hand-off
    deqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    // ring memory, head/tail/count, result and output registers
    deqs_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_op        (s_axis_tuser),
        .i_value     (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_data      (w_data),
        .o_back_data (w_back),
        .o_position  (w_pos),
        .o_occupancy (w_occ),
        .o_status    (w_status)
    );

    assign m_axis_tdata = TD_W'({w_occ, w_pos, w_back, w_data});
    assign m_axis_tuser = w_status;

    // one item in flight: ready drops right after an accept
    `ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "item accepted while busy")

    // occupancy never passes the ring size
    `ASSERT_IMPL(a_occ_bound, i_clk, i_rst_n, m_axis_tvalid, w_occ <= CW'(CAPACITY), "occupancy above capacity")

    // a refused push only happens on a full queue
    `ASSERT_IMPL(a_full_status, i_clk, i_rst_n, m_axis_tvalid && (w_status == deqs_pkg::ST_FULL), w_occ == CW'(CAPACITY), "full status with free room")

    // output register never overwritten while a result waits
    `ASSERT_IMPL(a_load_free, i_clk, i_rst_n, w_cmd.load_out, w_stat.out_free, "result overwritten")

endmodule

// ----- sim/deqs_checker.sv -----
`timescale 1ns / 1ps

// Watches both streams of the deque, keeps its own copy of the ring and
// compares every result item with the oldest outstanding prediction.
module deqs_checker #(
    parameter int CAPACITY = 1024,
    parameter int IW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1),
    parameter int TD_W     = ((2 * deqs_pkg::VAL_W + IW + CW + 7) / 8) * 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    input  logic                       i_s_tready,
    input  logic [deqs_pkg::VAL_W-1:0] i_s_tdata,   // value
    input  logic [deqs_pkg::OP_W-1:0]  i_s_tuser,   // op
    input  logic                       i_m_tvalid,
    input  logic                       i_m_tready,
    // data, back_data, position, occupancy, zero pad
    input  logic [TD_W-1:0]            i_m_tdata,
    input  logic [deqs_pkg::ST_W-1:0]  i_m_tuser,   // status
    output int                         o_fail_count,
    output int                         o_pending,
    output int                         o_checked
);

    localparam int OUT_W = 2 * deqs_pkg::VAL_W + IW + CW;

    typedef struct packed {
        logic [deqs_pkg::VAL_W-1:0] data;
        logic [deqs_pkg::VAL_W-1:0] back;
        logic [IW-1:0]              pos;
        logic [CW-1:0]              occ;
        logic [deqs_pkg::ST_W-1:0]  st;
    } t_deq_result;

    logic [deqs_pkg::VAL_W-1:0] words [CAPACITY];
    int                         head;
    int                         tail;
    int                         count;
    t_deq_result                pending_results [$];

    function automatic int next_slot(input int s);
        return (s + 1) % CAPACITY;
    endfunction

    function automatic int prev_slot(input int s);
        return (s + CAPACITY - 1) % CAPACITY;
    endfunction

    // applies one op to the shadow deque, returns the result it must give
    function automatic t_deq_result deque_apply(input logic [deqs_pkg::OP_W-1:0] op,
                                                input logic [deqs_pkg::VAL_W-1:0] val);
        t_deq_result r;
        int          k;
        r = '0;
        case (op)
            deqs_pkg::OP_PUSH_FRONT: begin
                if (count >= CAPACITY) begin
                    r.st = deqs_pkg::ST_FULL;
                end else begin
                    head = prev_slot(head);
                    words[IW'(head)] = val;
                    count++;
                end
            end
            deqs_pkg::OP_PUSH_BACK: begin
                if (count >= CAPACITY) begin
                    r.st = deqs_pkg::ST_FULL;
                end else begin
                    words[IW'(tail)] = val;
                    tail = next_slot(tail);
                    count++;
                end
            end
            deqs_pkg::OP_POP_FRONT: begin
                if (count == 0) begin
                    r.st = deqs_pkg::ST_EMPTY;
                end else begin
                    r.data = words[IW'(head)];
                    head = next_slot(head);
                    count--;
                end
            end
            deqs_pkg::OP_POP_BACK: begin
                if (count == 0) begin
                    r.st = deqs_pkg::ST_EMPTY;
                end else begin
                    tail = prev_slot(tail);
                    r.data = words[IW'(tail)];
                    count--;
                end
            end
            deqs_pkg::OP_PEEK: begin
                if (count == 0) begin
                    r.st = deqs_pkg::ST_EMPTY;
                end else begin
                    r.data = words[IW'(head)];
                    r.back = words[IW'(prev_slot(tail))];
                end
            end
            deqs_pkg::OP_FIND: begin
                r.st = deqs_pkg::ST_NOT_FOUND;
                for (k = 0; k < count; k++) begin
                    if (words[IW'((head + k) % CAPACITY)] == val) begin
                        r.pos = IW'(k);
                        r.st  = deqs_pkg::ST_OK;
                        break;
                    end
                end
            end
            default: ;   // unused codes leave the deque alone
        endcase
        r.occ = CW'(count);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_deq_result got;
        t_deq_result want;
        logic        pad_bad;
        if (!i_rst_n) begin
            head         = 0;
            tail         = 0;
            count        = 0;
            o_fail_count = 0;
            o_checked    = 0;
            pending_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.data = i_m_tdata[deqs_pkg::VAL_W-1:0];
                got.back = i_m_tdata[2*deqs_pkg::VAL_W-1:deqs_pkg::VAL_W];
                got.pos  = i_m_tdata[2*deqs_pkg::VAL_W+IW-1:2*deqs_pkg::VAL_W];
                got.occ  = i_m_tdata[OUT_W-1:2*deqs_pkg::VAL_W+IW];
                got.st   = i_m_tuser;
                pad_bad  = ((i_m_tdata >> OUT_W) !== '0);
                o_checked++;
                if (pending_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("[%0t] result item with nothing outstanding: data=%h st=%0d",
                                 $realtime, got.data, got.st);
                end else begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (got.data !== want.data || got.back !== want.back ||
                        got.pos !== want.pos || got.occ !== want.occ ||
                        got.st !== want.st || pad_bad) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"[%0t] result %0d mismatch: expected data=%h back=%h ",
                                      "pos=%0d occ=%0d st=%0d, got data=%h back=%h pos=%0d ",
                                      "occ=%0d st=%0d pad_ok=%0d"},
                                     $realtime, o_checked, want.data, want.back, want.pos,
                                     want.occ, want.st, got.data, got.back, got.pos,
                                     got.occ, got.st, !pad_bad);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                pending_results.insert(pending_results.size(),
                                       deque_apply(i_s_tuser, i_s_tdata));
        end
        o_pending = pending_results.size();
    end

endmodule

// ----- sim/tb_double_ended_queue_with_search.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the deque. Checking lives in deqs_checker.
module tb_double_ended_queue_with_search;

    localparam int CAPACITY  = 1024;
    localparam int IW        = $clog2(CAPACITY);
    localparam int CW        = $clog2(CAPACITY + 1);
    localparam int TD_W      = ((2 * deqs_pkg::VAL_W + IW + CW + 7) / 8) * 8;
    localparam int LONG_HOLD = 400;       // receiver hold-off, cycles
    localparam int MIXED_N   = 150;       // random items around low occupancy
    localparam int DRAIN_N   = 100;       // closing items, no idling
    localparam int REFUSE_N  = 20;        // full refusals wanted in the fill phase

    // op codes the block has to ignore
    localparam logic [deqs_pkg::OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [deqs_pkg::OP_W-1:0] OP_RSVD_7 = 3'd7;

    typedef enum {PH_MIXED, PH_FILL, PH_DRAIN} t_stim_phase;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [deqs_pkg::VAL_W-1:0] s_axis_tdata;
    logic [deqs_pkg::OP_W-1:0]  s_axis_tuser;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [TD_W-1:0]            m_axis_tdata;
    logic [deqs_pkg::ST_W-1:0]  m_axis_tuser;

    int chk_fail_count;
    int chk_pending;
    int chk_checked;

    // stimulus bookkeeping: a plain level count is enough to steer the phases
    int   level;
    int   peak_level;
    int   refused;
    int   empty_hits;
    int   items_sent;
    bit   quiet;          // no idling on either side
    bit   hold_req;       // ask the receiver for its long hold-off
    bit   hold_done;
    logic [deqs_pkg::VAL_W-1:0] recent_words [64];
    int   recent_cnt;

    double_ended_queue_with_search #(.CAPACITY(CAPACITY)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // value
        .s_axis_tuser  (s_axis_tuser),   // op
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // data, back_data, position, occupancy, pad
        .m_axis_tuser  (m_axis_tuser)    // status
    );

    deqs_checker #(.CAPACITY(CAPACITY), .TD_W(TD_W)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (chk_fail_count),
        .o_pending    (chk_pending),
        .o_checked    (chk_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop, set beyond the slowest legal run, which is every item a
    // full-depth find plus stalls.
    initial begin
        #12_000_000;
        $display("status: fail");
        $finish;
    end

    // Word mix: small pool (duplicates, so find has to pick the first hit),
    // the extremes, or anything.
    function automatic logic [deqs_pkg::VAL_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return deqs_pkg::VAL_W'($signed($urandom_range(0, 7)) - 4);
        if (r == 4) begin
            case ($urandom_range(0, 4))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                3: return 32'hFFFF_FFFF;
                default: return 32'h0000_0001;
            endcase
        end
        return $urandom();
    endfunction

    // Find keys: mostly words pushed recently so the scan hits somewhere.
    function automatic logic [deqs_pkg::VAL_W-1:0] pick_key();
        int r;
        int span;
        r = $urandom_range(0, 9);
        span = (recent_cnt < 64) ? recent_cnt : 64;
        if (r < 5 && span > 0)
            return recent_words[6'($urandom_range(0, span - 1))];
        return pick_word();
    endfunction

    function automatic logic [deqs_pkg::OP_W-1:0] pick_op(input t_stim_phase ph);
        int r;
        r = $urandom_range(0, 99);
        case (ph)
            PH_MIXED: begin
                if (r < 18) return deqs_pkg::OP_PUSH_FRONT;
                if (r < 36) return deqs_pkg::OP_PUSH_BACK;
                if (r < 52) return deqs_pkg::OP_POP_FRONT;
                if (r < 68) return deqs_pkg::OP_POP_BACK;
                if (r < 78) return deqs_pkg::OP_PEEK;
                if (r < 94) return deqs_pkg::OP_FIND;
            end
            PH_FILL: begin
                if (r < 47) return deqs_pkg::OP_PUSH_FRONT;
                if (r < 94) return deqs_pkg::OP_PUSH_BACK;
                if (r < 95) return deqs_pkg::OP_POP_FRONT;
                if (r < 96) return deqs_pkg::OP_POP_BACK;
                if (r < 97) return deqs_pkg::OP_PEEK;
                if (r < 99) return deqs_pkg::OP_FIND;
            end
            default: begin
                if (r < 10) return deqs_pkg::OP_PUSH_FRONT;
                if (r < 20) return deqs_pkg::OP_PUSH_BACK;
                if (r < 45) return deqs_pkg::OP_POP_FRONT;
                if (r < 70) return deqs_pkg::OP_POP_BACK;
                if (r < 80) return deqs_pkg::OP_PEEK;
                if (r < 97) return deqs_pkg::OP_FIND;
            end
        endcase
        return ($urandom_range(0, 1) != 0) ? OP_RSVD_7 : OP_RSVD_6;
    endfunction

    // Offer one item from a falling edge, optionally after a short gap, and
    // return at the falling edge after it was taken.
    task automatic send_item(input logic [deqs_pkg::OP_W-1:0] op,
                             input logic [deqs_pkg::VAL_W-1:0] val);
        int n;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid = 1'b0;
            n = $urandom_range(1, 7);
            repeat (n) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = val;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        items_sent++;
        case (op) inside
            deqs_pkg::OP_PUSH_FRONT, deqs_pkg::OP_PUSH_BACK: begin
                if (level < CAPACITY) begin
                    level++;
                    recent_words[6'(recent_cnt % 64)] = val;
                    recent_cnt++;
                end else begin
                    refused++;
                end
            end
            deqs_pkg::OP_POP_FRONT, deqs_pkg::OP_POP_BACK: begin
                if (level > 0) level--;
                else empty_hits++;
            end
            deqs_pkg::OP_PEEK: if (level == 0) empty_hits++;
            default: ;
        endcase
        if (level > peak_level) peak_level = level;
    endtask

    task automatic send_random(input t_stim_phase ph);
        logic [deqs_pkg::OP_W-1:0] op;
        op = pick_op(ph);
        send_item(op, (op == deqs_pkg::OP_FIND) ? pick_key() : pick_word());
    endtask

    // Receiver: random stalls, one long hold-off on request, none at the end.
    initial begin : receiver
        int n;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                m_axis_tready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_axis_tready = 1'b0;
                n = $urandom_range(1, 7);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    initial begin : stimulus
        int k;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = deqs_pkg::OP_PUSH_FRONT;
        level         = 0;
        peak_level    = 0;
        refused       = 0;
        empty_hits    = 0;
        items_sent    = 0;
        quiet         = 1'b0;
        hold_req      = 1'b0;
        hold_done     = 1'b0;
        recent_cnt    = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: everything on an empty queue first, unused codes too
        send_item(deqs_pkg::OP_POP_FRONT, 32'h0);
        send_item(deqs_pkg::OP_POP_BACK,  32'hFFFF_FFFF);
        send_item(deqs_pkg::OP_PEEK,      32'h0);
        send_item(deqs_pkg::OP_FIND,      32'h0);
        send_item(OP_RSVD_6,              32'hFFFF_FFFF);
        send_item(OP_RSVD_7,              32'h0);
        // extremes at both ends; the first front push wraps head below zero
        send_item(deqs_pkg::OP_PUSH_BACK,  32'h7FFF_FFFF);
        send_item(deqs_pkg::OP_PUSH_FRONT, 32'h8000_0000);
        send_item(deqs_pkg::OP_PUSH_BACK,  32'h0000_0000);
        send_item(deqs_pkg::OP_PUSH_BACK,  32'hFFFF_FFFF);
        send_item(deqs_pkg::OP_PUSH_FRONT, 32'h8000_0000);
        send_item(deqs_pkg::OP_PEEK,       32'h0);
        // duplicates: first match from the front wins
        send_item(deqs_pkg::OP_FIND, 32'h8000_0000);
        send_item(deqs_pkg::OP_FIND, 32'hFFFF_FFFF);     // last entry
        send_item(deqs_pkg::OP_FIND, 32'h0001_2345);     // absent
        send_item(deqs_pkg::OP_FIND, 32'h0000_0000);
        send_item(deqs_pkg::OP_POP_FRONT, 32'h0);
        send_item(deqs_pkg::OP_POP_BACK,  32'h0);
        send_item(deqs_pkg::OP_PEEK,      32'h0);
        send_item(deqs_pkg::OP_POP_FRONT, 32'h0);
        send_item(deqs_pkg::OP_POP_BACK,  32'h0);
        send_item(deqs_pkg::OP_PEEK,      32'h0);        // single entry: front == back
        send_item(deqs_pkg::OP_POP_FRONT, 32'h0);        // empties the queue
        send_item(deqs_pkg::OP_POP_BACK,  32'h0);
        send_item(deqs_pkg::OP_PEEK,      32'h0);

        // random, occupancy kept low so empty cases keep coming up
        for (k = 0; k < MIXED_N; k++) begin
            if (k == 60) hold_req = 1'b1;      // receiver stops, input backs up
            send_random(PH_MIXED);
        end

        // push-heavy until the queue has refused pushes for a while
        while (refused < REFUSE_N)
            send_random(PH_FILL);

        // closing stretch with no idling
        quiet = 1'b1;
        for (k = 0; k < DRAIN_N; k++)
            send_random(PH_DRAIN);
        s_axis_tvalid = 1'b0;

        // a find at full depth is the slowest item
        while (chk_pending != 0) @(posedge i_clk);
        repeat (CAPACITY + 16) @(posedge i_clk);

        $display("covered %0d items and %0d results; queue peaked at %0d words",
                 items_sent, chk_checked, peak_level);
        $display("pushes refused when full: %0d, pops/peeks on empty: %0d",
                 refused, empty_hits);
        if (chk_fail_count == 0 && chk_pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
